// ===== sv/tpq_pkg.sv =====
// Package for the typed packet queue: types, codes and constants.
// Used by typed_packet_queue and the testbench; tpq_ram does not use it.
// No dependencies.
package tpq_pkg;

  // Default queue depth and configuration register layout
  localparam int QUEUE_DEPTH_DEF = 64;
  localparam int CFG_W           = 7;
  localparam logic [CFG_W-1:0] MAX_ENTRIES_RST = 7'd64;

  // Output field widths
  localparam int CNT_OUT_W  = 7;
  localparam int BYTES_W    = 23;
  localparam int BYTES_OUT_W = 22;

  // Class code of a generic data packet
  localparam logic CLASS_DATA = 1'b0;

  typedef enum logic [1:0] {
    FUNC_ENQ        = 2'd0,
    FUNC_DEQ        = 2'd1,
    FUNC_PEEK_HEAD  = 2'd2,
    FUNC_PEEK_CLASS = 2'd3
  } tpq_func_e;

  typedef enum logic [1:0] {
    STAT_DONE = 2'd0,
    STAT_FULL = 2'd1,
    STAT_NONE = 2'd2
  } tpq_status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT
  } tpq_state_e;

  // One stored descriptor
  typedef struct packed {
    logic [15:0] handle;
    logic        cls;
    logic [15:0] nbytes;
    logic [31:0] stamp;
  } tpq_entry_t;

  localparam int ENTRY_W = $bits(tpq_entry_t);

endpackage

// ===== sv/typed_packet_queue.sv =====
// Typed packet queue: bounded descriptor queue with class-selective dequeue.
// Enqueue, and lookups on an empty queue, answer from the idle state; other lookups
//   scan from the head, one entry per cycle, to the first match or the last held entry
//   (peek head stops at entry 0); dequeue shifts the later entries down one per cycle.
// One item in flight at a time; a new request waits for idle and the last result to go.
// Reset clears counts and sets the limit to 64; the descriptor RAM is not cleared.
module typed_packet_queue #(
  parameter int QUEUE_DEPTH = tpq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tpq_pkg::CFG_W-1:0]     cfg_data_i,
  // input transaction
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    func_i,
  input  logic                          item_class_i,
  input  logic [15:0]                   entry_handle_i,
  input  logic [15:0]                   entry_bytes_i,
  input  logic [31:0]                   now_time_i,
  // result transaction
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    status_o,
  output logic [15:0]                   out_handle_o,
  output logic                          out_class_o,
  output logic [15:0]                   out_bytes_o,
  output logic [31:0]                   out_time_o,
  output logic [tpq_pkg::CNT_OUT_W-1:0] entry_count_o,
  output logic [tpq_pkg::BYTES_OUT_W-1:0] byte_total_o,
  output logic [tpq_pkg::CNT_OUT_W-1:0] data_count_o,
  output logic [tpq_pkg::CNT_OUT_W-1:0] request_count_o
);

  import tpq_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int LW = (CW > CNT_OUT_W) ? CW : CNT_OUT_W;

  tpq_state_e state_q, state_d;
  tpq_func_e  op_q, op_d;
  logic       cls_q, cls_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] data_q, data_d;
  logic [CW-1:0] req_q, req_d;
  logic [BYTES_W-1:0] bytes_q, bytes_d;
  logic [CFG_W-1:0]   lim_q, lim_d;
  logic          ovalid_q, ovalid_d;
  tpq_status_e   ostat_q, ostat_d;
  tpq_entry_t    oent_q, oent_d;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
  tpq_entry_t    rd_ent, in_ent;

  logic          in_acc;
  logic          full;
  logic          match;
  logic [CW-1:0] idx_p1, idx_p2;
  logic [LW-1:0] cnt_ext, lim_ext, data_ext, req_ext;

  // Descriptor storage
  tpq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_ent = tpq_entry_t'(ram_rdata);
  assign in_ent = '{handle: entry_handle_i, cls: item_class_i,
                    nbytes: entry_bytes_i, stamp: now_time_i};

  // Handshakes
  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE) && (!ovalid_q || out_ready_i);
  assign in_acc      = in_valid_i && in_ready_o;

  // Limit check: a limit above the depth acts as the depth
  assign cnt_ext = LW'(cnt_q);
  assign lim_ext = LW'(lim_q);
  assign full    = (cnt_ext >= lim_ext) || (cnt_q == CW'(QUEUE_DEPTH));

  assign idx_p1 = idx_q + CW'(1);
  assign idx_p2 = idx_q + CW'(2);
  assign match  = (op_q == FUNC_PEEK_HEAD) || (rd_ent.cls == cls_q);

  // Sequencer: next state, counters and RAM control
  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    cls_d    = cls_q;
    idx_d    = idx_q;
    cnt_d    = cnt_q;
    data_d   = data_q;
    req_d    = req_q;
    bytes_d  = bytes_q;
    lim_d    = lim_q;
    ovalid_d = ovalid_q && !out_ready_i;
    ostat_d  = ostat_q;
    oent_d   = oent_q;
    ram_we    = 1'b0;
    ram_waddr = cnt_q[AW-1:0];
    ram_wdata = ENTRY_W'(in_ent);
    ram_raddr = '0;

    if (cfg_valid_i) begin
      lim_d = cfg_data_i;
    end

    case (state_q)
      ST_IDLE: begin
        // head is read every idle cycle so a scan starts with entry 0 ready
        ram_raddr = '0;
        if (in_acc) begin
          op_d  = tpq_func_e'(func_i);
          cls_d = item_class_i;
          idx_d = '0;
          if (tpq_func_e'(func_i) == FUNC_ENQ) begin
            ovalid_d = 1'b1;
            oent_d   = '0;
            if (full) begin
              ostat_d = STAT_FULL;
            end else begin
              ostat_d = STAT_DONE;
              ram_we  = 1'b1;
              cnt_d   = cnt_q + CW'(1);
              if (item_class_i == CLASS_DATA) begin
                data_d = data_q + CW'(1);
              end else begin
                req_d = req_q + CW'(1);
              end
              bytes_d = bytes_q + BYTES_W'(entry_bytes_i);
            end
          end else if (cnt_q == '0) begin
            ovalid_d = 1'b1;
            ostat_d  = STAT_NONE;
            oent_d   = '0;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // rd_ent holds entry idx_q; fetch the next one
        ram_raddr = idx_p1[AW-1:0];
        if (match) begin
          oent_d  = rd_ent;
          ostat_d = STAT_DONE;
          if (op_q == FUNC_DEQ) begin
            if (rd_ent.cls == CLASS_DATA) begin
              if (data_q != '0) data_d = data_q - CW'(1);
            end else begin
              if (req_q != '0) req_d = req_q - CW'(1);
            end
            bytes_d = bytes_q - BYTES_W'(rd_ent.nbytes);
            state_d = ST_SHIFT;
          end else begin
            ovalid_d = 1'b1;
            state_d  = ST_IDLE;
          end
        end else if (idx_p1 == cnt_q) begin
          ostat_d  = STAT_NONE;
          oent_d   = '0;
          ovalid_d = 1'b1;
          state_d  = ST_IDLE;
        end else begin
          idx_d = idx_p1;
        end
      end

      ST_SHIFT: begin
        // rd_ent holds entry idx_q+1; move it down into idx_q
        ram_raddr = idx_p2[AW-1:0];
        ram_waddr = idx_q[AW-1:0];
        ram_wdata = ram_rdata;
        if (idx_p1 < cnt_q) begin
          ram_we = 1'b1;
          idx_d  = idx_p1;
        end else begin
          cnt_d    = cnt_q - CW'(1);
          ovalid_d = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control and counter registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      data_q   <= '0;
      req_q    <= '0;
      bytes_q  <= '0;
      lim_q    <= MAX_ENTRIES_RST;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      data_q   <= data_d;
      req_q    <= req_d;
      bytes_q  <= bytes_d;
      lim_q    <= lim_d;
      ovalid_q <= ovalid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    cls_q   <= cls_d;
    idx_q   <= idx_d;
    ostat_q <= ostat_d;
    oent_q  <= oent_d;
  end

  // Result outputs; counts stay put while a result waits
  assign data_ext = LW'(data_q);
  assign req_ext  = LW'(req_q);

  assign out_valid_o     = ovalid_q;
  assign status_o        = ostat_q;
  assign out_handle_o    = oent_q.handle;
  assign out_class_o     = oent_q.cls;
  assign out_bytes_o     = oent_q.nbytes;
  assign out_time_o      = oent_q.stamp;
  assign entry_count_o   = cnt_ext[CNT_OUT_W-1:0];
  assign byte_total_o    = bytes_q[BYTES_OUT_W-1:0];
  assign data_count_o    = data_ext[CNT_OUT_W-1:0];
  assign request_count_o = req_ext[CNT_OUT_W-1:0];

endmodule

// ===== sv/tpq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No package dependencies; used for the descriptor store.
module tpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for typed_packet_queue: directed corner cases, then random
// phases over several limits and idling patterns. Depends on tpq_pkg and the block.
module testbench;
  import tpq_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 80;
  localparam int PHASE_ITEMS    = 75;
  localparam int NUM_PHASES     = 8;

  // One request transaction as presented on the input port
  typedef struct packed {
    tpq_func_e   func;
    logic        cls;
    logic [15:0] handle;
    logic [15:0] nbytes;
    logic [31:0] stamp;
  } queue_request_t;

  // One result transaction as seen on the output port
  typedef struct packed {
    tpq_status_e            status;
    logic [15:0]            handle;
    logic                   cls;
    logic [15:0]            nbytes;
    logic [31:0]            stamp;
    logic [CNT_OUT_W-1:0]   entry_count;
    logic [BYTES_OUT_W-1:0] byte_total;
    logic [CNT_OUT_W-1:0]   data_count;
    logic [CNT_OUT_W-1:0]   request_count;
  } queue_result_t;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  // Shadow copy of the queue; predicts each result and checks it when it arrives
  class tpq_scoreboard;
    tpq_entry_t         held_slots[$];
    queue_result_t      expected_results[$];
    logic [CFG_W-1:0]   limit_reg;
    logic [BYTES_W-1:0] held_bytes;
    int unsigned        held_data;
    int unsigned        held_requests;
    int unsigned        errors;
    int unsigned        checked;
    int unsigned        drops;
    int unsigned        misses;
    int unsigned        peak;
    int unsigned        func_seen[4];

    function new();
      limit_reg     = MAX_ENTRIES_RST;
      held_bytes    = '0;
      held_data     = 0;
      held_requests = 0;
      errors        = 0;
      checked       = 0;
      drops         = 0;
      misses        = 0;
      peak          = 0;
    endfunction

    function void set_limit(logic [CFG_W-1:0] value);
      limit_reg = value;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // Apply an accepted request to the shadow queue and queue up its result
    function void note_request(queue_request_t req);
      queue_result_t res;
      tpq_entry_t    fresh;
      tpq_entry_t    hit;
      int            limit;
      int            pos;
      res        = '0;
      res.status = STAT_DONE;
      limit      = (limit_reg > QUEUE_DEPTH_DEF) ? QUEUE_DEPTH_DEF : int'(limit_reg);
      pos        = -1;
      func_seen[req.func]++;
      case (req.func)
        FUNC_ENQ: begin
          if (held_slots.size() >= limit) begin
            res.status = STAT_FULL;
            drops++;
          end else begin
            fresh.handle = req.handle;
            fresh.cls    = req.cls;
            fresh.nbytes = req.nbytes;
            fresh.stamp  = req.stamp;
            held_slots = {held_slots, fresh};
            if (req.cls == CLASS_DATA) held_data++;
            else held_requests++;
            held_bytes = held_bytes + BYTES_W'(req.nbytes);
          end
        end
        FUNC_PEEK_HEAD: pos = (held_slots.size() != 0) ? 0 : -1;
        default: begin
          foreach (held_slots[i])
            if (pos < 0 && held_slots[i].cls == req.cls) pos = i;
        end
      endcase
      // Lookups: report the entry found, dequeue also removes it and closes the gap
      if (req.func != FUNC_ENQ) begin
        if (pos < 0) begin
          res.status = STAT_NONE;
          misses++;
        end else begin
          hit        = held_slots[pos];
          res.handle = hit.handle;
          res.cls    = hit.cls;
          res.nbytes = hit.nbytes;
          res.stamp  = hit.stamp;
          if (req.func == FUNC_DEQ) begin
            if (hit.cls == CLASS_DATA) held_data--;
            else held_requests--;
            held_bytes = held_bytes - BYTES_W'(hit.nbytes);
            held_slots.delete(pos);
          end
        end
      end
      res.entry_count   = CNT_OUT_W'(held_slots.size());
      res.byte_total    = held_bytes[BYTES_OUT_W-1:0];
      res.data_count    = CNT_OUT_W'(held_data);
      res.request_count = CNT_OUT_W'(held_requests);
      if (held_slots.size() > peak) peak = held_slots.size();
      expected_results = {expected_results, res};
    endfunction

    function void compare_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(queue_result_t got);
      queue_result_t want;
      if (expected_results.size() == 0) begin
        $error("result transaction with no request outstanding");
        errors++;
        return;
      end
      want = expected_results.pop_front();
      checked++;
      compare_field("status", want.status, got.status);
      compare_field("out_handle", want.handle, got.handle);
      compare_field("out_class", want.cls, got.cls);
      compare_field("out_bytes", want.nbytes, got.nbytes);
      compare_field("out_time", want.stamp, got.stamp);
      compare_field("entry_count", want.entry_count, got.entry_count);
      compare_field("byte_total", want.byte_total, got.byte_total);
      compare_field("data_count", want.data_count, got.data_count);
      compare_field("request_count", want.request_count, got.request_count);
    endfunction
  endclass

  // DUT signals
  logic                   clk_i        = 1'b0;
  logic                   rst_ni       = 1'b0;
  logic                   cfg_valid_i  = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_W-1:0]       cfg_data_i   = '0;
  logic                   in_valid_i   = 1'b0;
  logic                   in_ready_o;
  logic [1:0]             func_i       = '0;
  logic                   item_class_i = 1'b0;
  logic [15:0]            entry_handle_i = '0;
  logic [15:0]            entry_bytes_i  = '0;
  logic [31:0]            now_time_i     = '0;
  logic                   out_valid_o;
  logic                   out_ready_i  = 1'b0;
  logic [1:0]             status_o;
  logic [15:0]            out_handle_o;
  logic                   out_class_o;
  logic [15:0]            out_bytes_o;
  logic [31:0]            out_time_o;
  logic [CNT_OUT_W-1:0]   entry_count_o;
  logic [BYTES_OUT_W-1:0] byte_total_o;
  logic [CNT_OUT_W-1:0]   data_count_o;
  logic [CNT_OUT_W-1:0]   request_count_o;

  tpq_scoreboard board;
  queue_result_t seen_result;
  int            send_idle_pct = 0;
  int            stall_pct     = 0;
  int            quiet_cycles  = 0;
  int            limit_writes  = 0;

  typed_packet_queue i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .func_i         (func_i),
    .item_class_i   (item_class_i),
    .entry_handle_i (entry_handle_i),
    .entry_bytes_i  (entry_bytes_i),
    .now_time_i     (now_time_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .out_handle_o   (out_handle_o),
    .out_class_o    (out_class_o),
    .out_bytes_o    (out_bytes_o),
    .out_time_o     (out_time_o),
    .entry_count_o  (entry_count_o),
    .byte_total_o   (byte_total_o),
    .data_count_o   (data_count_o),
    .request_count_o(request_count_o)
  );

  always #1 clk_i = ~clk_i;

  // Receiver: random back-pressure on the result channel
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_ready_i <= 1'b0;
    else out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen_result.status        = tpq_status_e'(status_o);
      seen_result.handle        = out_handle_o;
      seen_result.cls           = out_class_o;
      seen_result.nbytes        = out_bytes_o;
      seen_result.stamp         = out_time_o;
      seen_result.entry_count   = entry_count_o;
      seen_result.byte_total    = byte_total_o;
      seen_result.data_count    = data_count_o;
      seen_result.request_count = request_count_o;
      board.check_result(seen_result);
    end
  end

  // Watchdog: cycles without any transaction on any channel
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  task automatic set_idling(idle_mode_e mode);
    send_idle_pct = (mode == IDLE_SEND) ? 80 : (mode == IDLE_BOTH) ? 23 : 0;
    stall_pct     = (mode == IDLE_RECV) ? 80 : (mode == IDLE_BOTH) ? 23 : 0;
  endtask

  // Present one request, hold it until accepted, then hand it to the scoreboard
  task automatic send_request(queue_request_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    func_i         <= req.func;
    item_class_i   <= req.cls;
    entry_handle_i <= req.handle;
    entry_bytes_i  <= req.nbytes;
    now_time_i     <= req.stamp;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_request(req);
  endtask

  // Stop sending and wait for every outstanding result
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [CFG_W-1:0] value);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    board.set_limit(value);
    limit_writes++;
  endtask

  function automatic queue_request_t random_request(int enq_pct);
    queue_request_t req;
    int             pick;
    pick = $urandom_range(99);
    if (pick < enq_pct) begin
      req.func = FUNC_ENQ;
    end else begin
      pick = $urandom_range(9);
      req.func = (pick < 5) ? FUNC_DEQ : (pick < 7) ? FUNC_PEEK_HEAD : FUNC_PEEK_CLASS;
    end
    req.cls    = 1'($urandom_range(1));
    req.handle = 16'($urandom);
    req.nbytes = 16'($urandom);
    req.stamp  = $urandom;
    return req;
  endfunction

  // Corner cases: empty queue, field extremes, mid-queue removal, small limits
  task automatic run_directed();
    set_idling(IDLE_NONE);
    send_request('{FUNC_PEEK_HEAD, 1'b0, 16'h0000, 16'h0000, 32'h0});
    send_request('{FUNC_DEQ, 1'b0, 16'h0000, 16'h0000, 32'h0});
    send_request('{FUNC_PEEK_CLASS, 1'b1, 16'h0000, 16'h0000, 32'h0});
    send_request('{FUNC_ENQ, 1'b0, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF});
    send_request('{FUNC_ENQ, 1'b1, 16'h0000, 16'h0000, 32'h0});
    send_request('{FUNC_ENQ, 1'b0, 16'h1234, 16'h0001, 32'h1});
    send_request('{FUNC_PEEK_HEAD, 1'b1, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF});
    send_request('{FUNC_PEEK_CLASS, 1'b1, 16'h0000, 16'h0000, 32'h0});
    // request class sits in the middle: removal closes the gap
    send_request('{FUNC_DEQ, 1'b1, 16'h0000, 16'h0000, 32'h0});
    // queue not empty but nothing of the asked class
    send_request('{FUNC_DEQ, 1'b1, 16'h0000, 16'h0000, 32'h0});
    send_request('{FUNC_PEEK_CLASS, 1'b0, 16'h0000, 16'h0000, 32'h0});
    send_request('{FUNC_DEQ, 1'b0, 16'h0000, 16'h0000, 32'h0});
    send_request('{FUNC_DEQ, 1'b0, 16'h0000, 16'h0000, 32'h0});
    // zero limit drops everything
    write_limit(7'd0);
    send_request('{FUNC_ENQ, 1'b1, 16'hBEEF, 16'h00FF, 32'hDEAD_BEEF});
    write_limit(7'd2);
    send_request('{FUNC_ENQ, 1'b1, 16'hA5A5, 16'h5A5A, 32'hA5A5_5A5A});
    send_request('{FUNC_ENQ, 1'b0, 16'h5A5A, 16'hA5A5, 32'h5A5A_A5A5});
    send_request('{FUNC_ENQ, 1'b0, 16'h0F0F, 16'h0F0F, 32'h0F0F_0F0F});
    // limit lowered below the count: entries stay, enqueues drop
    write_limit(7'd1);
    send_request('{FUNC_ENQ, 1'b1, 16'hF0F0, 16'hF0F0, 32'hF0F0_F0F0});
    send_request('{FUNC_PEEK_CLASS, 1'b0, 16'h0000, 16'h0000, 32'h0});
    send_request('{FUNC_DEQ, 1'b1, 16'h0000, 16'h0000, 32'h0});
    send_request('{FUNC_DEQ, 1'b0, 16'h0000, 16'h0000, 32'h0});
  endtask

  initial begin
    logic [CFG_W-1:0] limit;
    int               enq_pct;
    board = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();

    // Random phases: fill to the top, hold above-depth limits, squeeze, drain
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: begin limit = 7'd64;  enq_pct = 90; end
        1: begin limit = 7'd127; enq_pct = 60; end
        2: begin limit = 7'd5;   enq_pct = 30; end
        3: begin limit = 7'd0;   enq_pct = 25; end
        4: begin limit = 7'd65;  enq_pct = 75; end
        5: begin limit = CFG_W'($urandom_range(20, 1)); enq_pct = 50; end
        6: begin limit = 7'd64;  enq_pct = 35; end
        default: begin limit = CFG_W'($urandom_range(127)); enq_pct = 55; end
      endcase
      write_limit(limit);
      set_idling(idle_mode_e'(phase % 4));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // now and then let the queue go fully quiet before the next request
        if ($urandom_range(49) == 0) wait_drained();
        send_request(random_request(enq_pct));
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (board.pending() != 0) begin
      $error("%0d expected results never arrived", board.pending());
      board.errors++;
    end

    $display("Covered %0d enqueues, %0d dequeues, %0d head peeks, %0d class peeks; %0d limits.",
             board.func_seen[FUNC_ENQ], board.func_seen[FUNC_DEQ],
             board.func_seen[FUNC_PEEK_HEAD], board.func_seen[FUNC_PEEK_CLASS], limit_writes);
    $display("%0d results checked, %0d drops at the limit, %0d empty lookups, peak depth %0d.",
             board.checked, board.drops, board.misses, board.peak);
    if (board.errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/tpq_pkg.sv
sv/tpq_ram.sv
sv/typed_packet_queue.sv
tb/testbench.sv
